@@ rtl/extent_first_fit_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// extent first-fit allocator assertion macros
// shared concurrent checks, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef EXTENT_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define EXTENT_FIRST_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define EFA_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/efa_pkg.sv @@
// ----------------------------------------------------------------------------
// efa_pkg
// types, widths and constants shared by the extent allocator modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efa_pkg;

  // configuration register widths
  localparam int TS_W      = 16;
  localparam int VS_W      = 24;
  localparam int SB_W      = 13;
  localparam int EB_W      = 7;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // word field widths
  localparam int REQ_W   = 24;
  localparam int GADDR_W = 32;
  localparam int ENTRY_W = 7;

  // internal arithmetic widths
  localparam int ADDR_W       = 34;
  localparam int LIMIT_W      = 33;
  localparam int PROD_W       = VS_W + SB_W;
  localparam int DIV_W        = 33;
  localparam int SECTOR_SHIFT = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_CAP = 33'h1_0000_0000;

  localparam int DEFAULT_MAX_EXTENTS = 128;

  // configuration reset values
  localparam logic [TS_W-1:0] RST_TABLE_SECTOR   = 16'd201;
  localparam logic [VS_W-1:0] RST_VOLUME_SECTORS = 24'd2880;
  localparam logic [SB_W-1:0] RST_SECTOR_BYTES   = 13'd512;
  localparam logic [EB_W-1:0] RST_ENTRY_BYTES    = 7'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SECTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SECTORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BYTES    = 2'd3;

  // command codes
  localparam logic CMD_ALLOCATE = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  typedef struct packed {
    logic             command;
    logic [REQ_W-1:0] request_length;
  } item_t;

  typedef struct packed {
    logic [GADDR_W-1:0] granted_address;
    logic [ENTRY_W-1:0] entry_index;
    logic               found;
    logic               table_full;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_TEST,
    ST_SCAN,
    ST_PREDIV,
    ST_DIV,
    ST_JUMP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic set_limit;
    logic test;
    logic scan_start;
    logic scan_run;
    logic div_init;
    logic div_step;
    logic jump;
    logic fin_found;
    logic fin_fail;
    logic fin_clear;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic cand_below;
    logic count_zero;
    logic scan_hit;
    logic scan_clear;
    logic div_last;
  } dp_sts_t;

endpackage

@@ rtl/efa_datapath.sv @@
// ----------------------------------------------------------------------------
// efa_datapath
// extent table memory, candidate address, overlap compare and remainder unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "extent_first_fit_allocator_macros.svh"

module efa_datapath #(
  parameter int MAX_EXTENTS = efa_pkg::DEFAULT_MAX_EXTENTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [efa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [efa_pkg::CFG_W-1:0]           cfg_data,
  input  efa_pkg::item_t                      item,
  input  efa_pkg::dp_cmd_t                    cmd,
  output efa_pkg::dp_sts_t                    sts,
  output logic                                done,
  output efa_pkg::result_t                    result
);

  localparam int IW      = $clog2(MAX_EXTENTS);
  localparam int CW      = $clog2(MAX_EXTENTS + 1);
  localparam int ADDR_W  = efa_pkg::ADDR_W;
  localparam int REQ_W   = efa_pkg::REQ_W;
  localparam int DIV_W   = efa_pkg::DIV_W;
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int PROD_W  = efa_pkg::PROD_W;
  localparam int LIMIT_W = efa_pkg::LIMIT_W;

  // configuration
  logic [efa_pkg::TS_W-1:0] table_sector;
  logic [efa_pkg::VS_W-1:0] volume_sectors;
  logic [efa_pkg::SB_W-1:0] sector_bytes;
  logic [efa_pkg::EB_W-1:0] entry_bytes;

  // extent table
  logic [efa_pkg::GADDR_W-1:0] mem_start [MAX_EXTENTS];
  logic [REQ_W-1:0]            mem_len   [MAX_EXTENTS];
  logic [efa_pkg::GADDR_W-1:0] rd_start;
  logic [REQ_W-1:0]            rd_len;
  logic [CW-1:0]               extent_count;

  // request and search state
  logic                is_clear;
  logic [REQ_W-1:0]    req;
  logic [REQ_W-1:0]    len;
  logic [ADDR_W-1:0]   base;
  logic [PROD_W-1:0]   product;
  logic [LIMIT_W-1:0]  limit;
  logic [ADDR_W-1:0]   cand;
  logic [ADDR_W:0]     cand_top;
  logic [CW-1:0]       issue_idx;
  logic                cmp_valid;
  logic                cmp_last;
  logic [ADDR_W-1:0]   hit_end;

  // remainder unit
  logic [DIV_W-1:0]    dividend;
  logic [REQ_W-1:0]    rem;
  logic [DCNT_W-1:0]   div_cnt;
  logic [REQ_W:0]      rem_shift;

  logic [ADDR_W-1:0]   ext_end;
  logic                overlap;
  logic                full;
  logic                finishing;
  logic [efa_pkg::GADDR_W-1:0] fin_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_sector   <= efa_pkg::RST_TABLE_SECTOR;
      volume_sectors <= efa_pkg::RST_VOLUME_SECTORS;
      sector_bytes   <= efa_pkg::RST_SECTOR_BYTES;
      entry_bytes    <= efa_pkg::RST_ENTRY_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        efa_pkg::CFG_TABLE_SECTOR:   table_sector   <= cfg_data[efa_pkg::TS_W-1:0];
        efa_pkg::CFG_VOLUME_SECTORS: volume_sectors <= cfg_data[efa_pkg::VS_W-1:0];
        efa_pkg::CFG_SECTOR_BYTES:   sector_bytes   <= cfg_data[efa_pkg::SB_W-1:0];
        efa_pkg::CFG_ENTRY_BYTES:    entry_bytes    <= cfg_data[efa_pkg::EB_W-1:0];
        default: ;
      endcase
    end
  end

  // overlap test against the stored extent, end byte inclusive
  assign ext_end   = ADDR_W'(rd_start) + ADDR_W'(rd_len);
  assign overlap   = cmp_valid && (cand <= ext_end) && (cand_top >= (ADDR_W+1)'(rd_start));
  assign rem_shift = {rem, dividend[DIV_W-1]};
  assign full      = (extent_count == CW'(MAX_EXTENTS));
  assign finishing = cmd.fin_found || cmd.fin_fail;
  assign fin_addr  = cmd.fin_found ? cand[efa_pkg::GADDR_W-1:0] : '0;

  assign sts.is_clear   = is_clear;
  assign sts.cand_below = (cand < ADDR_W'(limit));
  assign sts.count_zero = (extent_count == '0);
  assign sts.scan_hit   = overlap;
  assign sts.scan_clear = cmp_valid && cmp_last && !overlap;
  assign sts.div_last   = (div_cnt == '0);

  // table read, one entry a cycle, and append of the finished extent
  always_ff @(posedge clk) begin
    rd_start <= mem_start[issue_idx[IW-1:0]];
    rd_len   <= mem_len[issue_idx[IW-1:0]];
    if (finishing && !full) begin
      mem_start[extent_count[IW-1:0]] <= fin_addr;
      mem_len[extent_count[IW-1:0]]   <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_clear <= (item.command == efa_pkg::CMD_CLEAR);
      req      <= item.request_length;
      len      <= (item.request_length == '0) ? REQ_W'(1) : item.request_length;
      base     <= (ADDR_W'(table_sector) << efa_pkg::SECTOR_SHIFT)
                  + ADDR_W'(entry_bytes) * ADDR_W'(MAX_EXTENTS);
      product  <= (volume_sectors == '0) ? '0
                  : PROD_W'(volume_sectors - 1'b1) * PROD_W'(sector_bytes);
    end
    if (cmd.set_limit) begin
      limit <= (product > PROD_W'(efa_pkg::LIMIT_CAP)) ? efa_pkg::LIMIT_CAP
               : LIMIT_W'(product);
      cand  <= base;
    end
    if (cmd.test) begin
      cand_top <= (ADDR_W+1)'(cand) + (ADDR_W+1)'(len) - 1'b1;
    end
    if (cmd.scan_run && overlap) begin
      hit_end <= ext_end;
    end
    if (cmd.div_init) begin
      dividend <= DIV_W'(hit_end - base);
      rem      <= '0;
      div_cnt  <= DCNT_W'(DIV_W - 1);
    end
    if (cmd.div_step) begin
      if (rem_shift >= {1'b0, len}) begin
        rem <= REQ_W'(rem_shift - {1'b0, len});
      end else begin
        rem <= rem_shift[REQ_W-1:0];
      end
      dividend <= dividend << 1;
      div_cnt  <= div_cnt - 1'b1;
    end
    // first candidate past the extent end on the base + k*len grid
    if (cmd.jump) begin
      cand <= hit_end - ADDR_W'(rem) + ADDR_W'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      cmp_valid <= 1'b0;
      cmp_last  <= 1'b0;
    end else if (cmd.scan_start) begin
      issue_idx <= '0;
      cmp_valid <= 1'b0;
      cmp_last  <= 1'b0;
    end else if (cmd.scan_run) begin
      if (issue_idx < extent_count) begin
        issue_idx <= issue_idx + 1'b1;
        cmp_valid <= 1'b1;
        cmp_last  <= (issue_idx == extent_count - 1'b1);
      end else begin
        cmp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_count <= '0;
      done         <= 1'b0;
    end else begin
      done <= finishing || cmd.fin_clear;
      if (cmd.fin_clear) begin
        extent_count <= '0;
      end else if (finishing && !full) begin
        extent_count <= extent_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_clear) begin
      result <= '0;
    end else if (finishing) begin
      result.granted_address <= fin_addr;
      result.found           <= cmd.fin_found;
      result.table_full      <= full;
      result.entry_index     <= full ? '0 : efa_pkg::ENTRY_W'(extent_count);
    end
  end

  `EFA_ASSERT_HOLDS(a_found_below_limit, done && result.found,
    {1'b0, result.granted_address} < limit, "granted address beyond search limit")
  `EFA_ASSERT_HOLDS(a_rem_below_len, cmd.div_step, rem < len,
    "remainder not below request length")
  `EFA_ASSERT_NEXT(a_append_counts, finishing && !full,
    extent_count == CW'($past(extent_count) + 1'b1), "append did not advance count")

endmodule

@@ rtl/efa_ctrl.sv @@
// ----------------------------------------------------------------------------
// efa_ctrl
// sequencer for setup, table scans, remainder steps and result issue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "extent_first_fit_allocator_macros.svh"

module efa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  efa_pkg::dp_sts_t  sts,
  output efa_pkg::dp_cmd_t  cmd
);

  efa_pkg::state_t state;
  efa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      efa_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = efa_pkg::ST_SETUP;
        end
      end
      efa_pkg::ST_SETUP: begin
        if (sts.is_clear) begin
          cmd.fin_clear = 1'b1;
          state_next    = efa_pkg::ST_IDLE;
        end else begin
          cmd.set_limit = 1'b1;
          state_next    = efa_pkg::ST_TEST;
        end
      end
      efa_pkg::ST_TEST: begin
        cmd.test = 1'b1;
        if (!sts.cand_below) begin
          cmd.fin_fail = 1'b1;
          state_next   = efa_pkg::ST_IDLE;
        end else if (sts.count_zero) begin
          cmd.fin_found = 1'b1;
          state_next    = efa_pkg::ST_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = efa_pkg::ST_SCAN;
        end
      end
      efa_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_hit) begin
          state_next = efa_pkg::ST_PREDIV;
        end else if (sts.scan_clear) begin
          cmd.fin_found = 1'b1;
          state_next    = efa_pkg::ST_IDLE;
        end
      end
      efa_pkg::ST_PREDIV: begin
        cmd.div_init = 1'b1;
        state_next   = efa_pkg::ST_DIV;
      end
      efa_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = efa_pkg::ST_JUMP;
        end
      end
      efa_pkg::ST_JUMP: begin
        cmd.jump   = 1'b1;
        state_next = efa_pkg::ST_TEST;
      end
      default: begin
        state_next = efa_pkg::ST_IDLE;
      end
    endcase
  end

  `EFA_ASSERT_NEXT(a_finish_to_idle, cmd.fin_found || cmd.fin_fail || cmd.fin_clear,
    state == efa_pkg::ST_IDLE, "finish did not return to idle")
  `EFA_ASSERT_HOLDS(a_scan_has_entries, cmd.scan_run, !sts.count_zero,
    "table scan with empty table")

endmodule

@@ rtl/extent_first_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// extent_first_fit_allocator
// first-fit search of an extent table with allocate (append) and clear commands
// clear: done strobes from its register after the setup state issues the clear
// allocate: setup, then per candidate a limit test, plus a scan of the entries
//   when the candidate is in range and the table is not empty, and the 33-step
//   remainder unit per rejected candidate; the table is read one entry a cycle
// results strobe for one cycle and cannot be stalled; busy is high while working
// reset: configuration to defaults, table emptied, controller idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module extent_first_fit_allocator #(
  parameter int MAX_EXTENTS = efa_pkg::DEFAULT_MAX_EXTENTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  efa_pkg::item_t                 item,
  output logic                           done,
  output efa_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [efa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efa_pkg::CFG_W-1:0]      cfg_data
);

  efa_pkg::dp_cmd_t cmd;
  efa_pkg::dp_sts_t sts;

  efa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  efa_datapath #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

endmodule
